FILE: hdl/i2c_master_transaction_sequencer_assert.svh
// Assertion macros shared by the sequencer checker.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define I2CS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define I2CS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/i2cs_pkg.sv
// Shared types, codes and constants of the I2C transaction sequencer.
`default_nettype none

package i2cs_pkg;

    localparam int BUFFER_DEPTH = 32;

    // Wide enough for any buffer index, from a slot or from the transfer count
    localparam int IDX_W = 8;

    localparam logic [5:0] COUNT_MAX = 6'd63;
    localparam logic       READ_FLAG = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_CONTINUE = 3'd1,
        CMD_START    = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_ACK      = 3'd4,
        CMD_NACK     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_BUF_WRITE = 2'd0,
        KIND_BUF_READ  = 2'd1,
        KIND_START     = 2'd2,
        KIND_EVENT     = 2'd3
    } kind_t;

    localparam logic [3:0] ST_START       = 4'd0;
    localparam logic [3:0] ST_RSTART      = 4'd1;
    localparam logic [3:0] ST_SLAW_ACK    = 4'd2;
    localparam logic [3:0] ST_TXDATA_ACK  = 4'd4;
    localparam logic [3:0] ST_ARBLOST     = 4'd6;
    localparam logic [3:0] ST_SLAR_ACK    = 4'd7;
    localparam logic [3:0] ST_RXDATA_ACK  = 4'd9;
    localparam logic [3:0] ST_RXDATA_NACK = 4'd10;

    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_TX_LENGTH  = 2'd1;
    localparam logic [1:0] REG_RX_LENGTH  = 2'd2;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       finished;
    } result_t;

    // Decision made at accept, resolved once the buffer read data lands
    typedef struct packed {
        cmd_t       command;
        logic [7:0] byte_val;
        logic       use_mem;
        logic       in_range;
        logic       data_valid;
    } stage_t;

endpackage

`default_nettype wire

FILE: hdl/i2c_master_transaction_sequencer.sv
// Top level of the I2C write-then-read transaction sequencer.
// Takes one item per clock while in_stall is low. Each item touches the
// single-port byte buffer at most once, at the edge it is accepted, where the
// buffer read data is also registered; its result is formed in the next cycle
// and registered into a two-entry output queue, which offers it on the output.
// in_stall rises only when the output queue plus the item in flight would
// overfill. The buffer is not cleared at reset: read only entries already
// written. Registers (APB): slave_address at 0x0, tx_length at 0x4,
// rx_length at 0x8; write them only while the block is idle.
`default_nettype none

module i2c_master_transaction_sequencer #(
    parameter int BUFFER_DEPTH = i2cs_pkg::BUFFER_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  status,
    input  wire logic [7:0]  byte_in,
    input  wire logic [4:0]  slot,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  command,
    output logic      [7:0]  data_byte,
    output logic             data_valid,
    output logic             finished
);

    logic [6:0]        slave_address_reg;
    logic [5:0]        tx_length_reg;
    logic [5:0]        rx_length_reg;
    logic              cfg_write;
    logic              accept;
    logic              push, pop, q_not_empty;
    logic [1:0]        q_fill;
    i2cs_pkg::result_t push_data, head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 7'd0;
            tx_length_reg     <= 6'd0;
            rx_length_reg     <= 6'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                i2cs_pkg::REG_SLAVE_ADDR: slave_address_reg <= pwdata[6:0];
                i2cs_pkg::REG_TX_LENGTH:  tx_length_reg     <= pwdata[5:0];
                i2cs_pkg::REG_RX_LENGTH:  rx_length_reg     <= pwdata[5:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            i2cs_pkg::REG_SLAVE_ADDR: prdata = {25'd0, slave_address_reg};
            i2cs_pkg::REG_TX_LENGTH:  prdata = {26'd0, tx_length_reg};
            i2cs_pkg::REG_RX_LENGTH:  prdata = {26'd0, rx_length_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Hold off while queue content plus the item in flight leaves no room
    assign pop      = q_not_empty && !out_stall;
    assign in_stall = ({1'b0, q_fill} + {2'b00, push}) > (3'd1 + {2'b00, pop});
    assign accept   = in_valid && !in_stall;

    i2cs_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .kind          (kind),
        .status        (status),
        .byte_in       (byte_in),
        .slot          (slot),
        .slave_address (slave_address_reg),
        .tx_length     (tx_length_reg),
        .rx_length     (rx_length_reg),
        .push          (push),
        .push_data     (push_data)
    );

    i2cs_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (q_not_empty),
        .fill      (q_fill),
        .head      (head)
    );

    assign out_valid  = q_not_empty;
    assign command    = head.command;
    assign data_byte  = head.data_byte;
    assign data_valid = head.data_valid;
    assign finished   = head.finished;

endmodule

`default_nettype wire

FILE: hdl/i2cs_buf_ram.sv
// Single-port byte buffer with registered read data.
`default_nettype none

module i2cs_buf_ram #(
    parameter int DEPTH = i2cs_pkg::BUFFER_DEPTH,
    parameter int AW    = $clog2(i2cs_pkg::BUFFER_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2cs_seq.sv
// Transaction decision logic, count and read-bit state, and the buffer access stage.
`default_nettype none

module i2cs_seq #(
    parameter int BUFFER_DEPTH = i2cs_pkg::BUFFER_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        kind,
    input  wire logic [3:0]        status,
    input  wire logic [7:0]        byte_in,
    input  wire logic [4:0]        slot,
    input  wire logic [6:0]        slave_address,
    input  wire logic [5:0]        tx_length,
    input  wire logic [5:0]        rx_length,
    output logic                   push,
    output i2cs_pkg::result_t      push_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [5:0]                     count_reg, count_next;
    logic                           rbit_reg, rbit_next;
    logic [5:0]                     cnt_inc;
    logic [i2cs_pkg::IDX_W-1:0]     idx_wide;
    logic                           want_wr, want_rd, in_range;
    logic                           ram_en;
    logic [7:0]                     ram_rdata;
    i2cs_pkg::stage_t               stage_next;
    i2cs_pkg::stage_t               stage_reg;
    logic                           s1_valid_reg;

    assign cnt_inc = (count_reg == i2cs_pkg::COUNT_MAX) ? count_reg : count_reg + 6'd1;

    always_comb
    begin
        count_next          = count_reg;
        rbit_next           = rbit_reg;
        want_wr             = 1'b0;
        want_rd             = 1'b0;
        idx_wide            = {3'b000, slot};
        stage_next.command  = i2cs_pkg::CMD_NONE;
        stage_next.byte_val = 8'h00;
        stage_next.use_mem  = 1'b0;
        stage_next.data_valid = 1'b0;
        unique case (i2cs_pkg::kind_t'(kind))
            i2cs_pkg::KIND_BUF_WRITE:
            begin
                want_wr = 1'b1;
            end
            i2cs_pkg::KIND_BUF_READ:
            begin
                want_rd               = 1'b1;
                stage_next.use_mem    = 1'b1;
                stage_next.data_valid = 1'b1;
            end
            i2cs_pkg::KIND_START:
            begin
                rbit_next          = (tx_length == 6'd0);
                stage_next.command = i2cs_pkg::CMD_START;
            end
            i2cs_pkg::KIND_EVENT:
            begin
                unique case (status)
                    i2cs_pkg::ST_START, i2cs_pkg::ST_RSTART:
                    begin
                        count_next            = 6'd0;
                        stage_next.command    = i2cs_pkg::CMD_CONTINUE;
                        stage_next.byte_val   = {slave_address,
                                                 rbit_reg & i2cs_pkg::READ_FLAG};
                        stage_next.data_valid = 1'b1;
                    end
                    i2cs_pkg::ST_SLAW_ACK, i2cs_pkg::ST_TXDATA_ACK:
                    begin
                        if (count_reg < tx_length)
                        begin
                            // Fetch the next transmit byte from the buffer
                            idx_wide              = {2'b00, count_reg};
                            want_rd               = 1'b1;
                            count_next            = cnt_inc;
                            stage_next.command    = i2cs_pkg::CMD_CONTINUE;
                            stage_next.use_mem    = 1'b1;
                            stage_next.data_valid = 1'b1;
                        end
                        else if (rx_length != 6'd0)
                        begin
                            rbit_next          = 1'b1;
                            stage_next.command = i2cs_pkg::CMD_START;
                        end
                        else
                        begin
                            stage_next.command = i2cs_pkg::CMD_STOP;
                        end
                    end
                    i2cs_pkg::ST_ARBLOST:
                    begin
                        stage_next.command = i2cs_pkg::CMD_NONE;
                    end
                    i2cs_pkg::ST_SLAR_ACK:
                    begin
                        stage_next.command = (rx_length > 6'd1) ? i2cs_pkg::CMD_ACK
                                                                : i2cs_pkg::CMD_NACK;
                    end
                    i2cs_pkg::ST_RXDATA_ACK:
                    begin
                        idx_wide   = {2'b00, count_reg};
                        want_wr    = 1'b1;
                        count_next = cnt_inc;
                        stage_next.command = (({1'b0, cnt_inc} + 7'd1) < {1'b0, rx_length})
                                             ? i2cs_pkg::CMD_ACK : i2cs_pkg::CMD_NACK;
                    end
                    i2cs_pkg::ST_RXDATA_NACK:
                    begin
                        idx_wide           = {2'b00, count_reg};
                        want_wr            = 1'b1;
                        count_next         = cnt_inc;
                        stage_next.command = i2cs_pkg::CMD_STOP;
                    end
                    default:
                    begin
                        stage_next.command = i2cs_pkg::CMD_STOP;
                    end
                endcase
            end
            default:
            begin
                stage_next.command = i2cs_pkg::CMD_NONE;
            end
        endcase
        in_range            = ({1'b0, idx_wide} < 9'(BUFFER_DEPTH));
        stage_next.in_range = in_range;
    end

    assign ram_en = accept && (want_wr || want_rd) && in_range;

    i2cs_buf_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (want_wr),
        .addr  (idx_wide[AW-1:0]),
        .wdata (byte_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 6'd0;
            rbit_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
                rbit_reg  <= rbit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    // Out-of-range reads answer zero
    always_comb
    begin
        push                 = s1_valid_reg;
        push_data.command    = stage_reg.command;
        push_data.data_valid = stage_reg.data_valid;
        push_data.finished   = (stage_reg.command == i2cs_pkg::CMD_STOP);
        if (stage_reg.use_mem)
        begin
            push_data.data_byte = stage_reg.in_range ? ram_rdata : 8'h00;
        end
        else
        begin
            push_data.data_byte = stage_reg.byte_val;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2cs_out_q.sv
// Two-entry result queue that decouples the output side from the sequencer.
`default_nettype none

module i2cs_out_q (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire i2cs_pkg::result_t push_data,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [1:0]             fill,
    output i2cs_pkg::result_t      head
);

    i2cs_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        fill_reg;

    assign not_empty = (fill_reg != 2'd0);
    assign fill      = fill_reg;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2cs_checker.sv
// Port-level checker for the sequencer, bound to the top level.
`default_nettype none

`include "i2c_master_transaction_sequencer_assert.svh"

module i2cs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] command,
    input wire logic [7:0] data_byte,
    input wire logic       data_valid,
    input wire logic       finished
);

    `I2CS_ASSERT_NOW(a_finished_on_stop, clk, rst_n, out_valid, finished == (command == i2cs_pkg::CMD_STOP), "finished must flag exactly a stop command")

    `I2CS_ASSERT_NOW(a_zero_when_no_data, clk, rst_n, out_valid && !data_valid, data_byte == 8'h00, "data_byte must be zero without data_valid")

    `I2CS_ASSERT_NOW(a_continue_carries_byte, clk, rst_n, out_valid && (command == i2cs_pkg::CMD_CONTINUE), data_valid, "continue must carry a byte to load")

    `I2CS_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(command) && $stable(data_byte) && $stable(data_valid), "stalled result must hold")

endmodule

bind i2c_master_transaction_sequencer i2cs_checker u_i2cs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .data_byte  (data_byte),
    .data_valid (data_valid),
    .finished   (finished)
);

`default_nettype wire

FILE: verif/tb_i2c_master_transaction_sequencer.sv
// Self-checking testbench for the I2C write-then-read transaction sequencer.
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer;
    import i2cs_pkg::*;

    localparam logic [3:0] ST_SLAW_NACK   = 4'd3;
    localparam logic [3:0] ST_TXDATA_NACK = 4'd5;
    localparam logic [3:0] ST_SLAR_NACK   = 4'd8;
    localparam logic [3:0] ST_OTHER       = 4'd11;
    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         QUIET_LIMIT    = 4000;
    localparam int         PHASES         = 14;
    localparam int         PHASE_ITEMS    = 135;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] status;
        logic [7:0] byte_in;
        logic [4:0] slot;
        logic       drain_first;
    } stim_t;

    typedef struct packed {
        logic [31:0][7:0] mem;
        logic [31:0]      written;
        logic [5:0]       count;
        logic             read_bit;
        logic [6:0]       addr;
        logic [5:0]       tx_len;
        logic [5:0]       rx_len;
    } seq_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [3:0]  status = '0;
    logic [7:0]  byte_in = '0;
    logic [4:0]  slot = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        finished;

    // bus_state follows accepted items, plan_state follows queued items
    seq_state_t bus_state = '0;
    seq_state_t plan_state = '0;
    stim_t      pending_items[$];
    result_t    pending_results[$];
    int         items_sent = 0;
    int         items_taken = 0;
    int         results_seen = 0;
    int         fault_count = 0;
    int         queued_items = 0;
    int         quiet_cycles = 0;
    int         send_left = 0;
    int         send_calm = 0;
    int         stall_left = 0;
    int         stall_mark = 0;
    int         recv_calm = 0;

    i2c_master_transaction_sequencer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .status     (status),
        .byte_in    (byte_in),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .command    (command),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .finished   (finished)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic result_t sequencer_next(inout seq_state_t s, input stim_t it);
        result_t r;
        r.command    = CMD_NONE;
        r.data_byte  = 8'h00;
        r.data_valid = 1'b0;
        case (it.kind)
            KIND_BUF_WRITE:
            begin
                s.mem[it.slot]     = it.byte_in;
                s.written[it.slot] = 1'b1;
            end
            KIND_BUF_READ:
            begin
                r.data_byte  = s.mem[it.slot];
                r.data_valid = 1'b1;
            end
            KIND_START:
            begin
                s.read_bit = (s.tx_len == 6'd0);
                r.command  = CMD_START;
            end
            default:
            begin
                case (it.status)
                    ST_START, ST_RSTART:
                    begin
                        s.count      = 6'd0;
                        r.command    = CMD_CONTINUE;
                        r.data_byte  = {s.addr, s.read_bit};
                        r.data_valid = 1'b1;
                    end
                    ST_SLAW_ACK, ST_TXDATA_ACK:
                    begin
                        if (s.count < s.tx_len)
                        begin
                            // indices past the buffer load zero
                            r.command    = CMD_CONTINUE;
                            r.data_valid = 1'b1;
                            r.data_byte  = s.count[5] ? 8'h00 : s.mem[s.count[4:0]];
                            if (s.count != COUNT_MAX)
                                s.count = s.count + 6'd1;
                        end
                        else if (s.rx_len != 6'd0)
                        begin
                            s.read_bit = 1'b1;
                            r.command  = CMD_START;
                        end
                        else
                            r.command = CMD_STOP;
                    end
                    ST_ARBLOST:
                        r.command = CMD_NONE;
                    ST_SLAR_ACK:
                        r.command = (s.rx_len > 6'd1) ? CMD_ACK : CMD_NACK;
                    ST_RXDATA_ACK, ST_RXDATA_NACK:
                    begin
                        if (!s.count[5])
                        begin
                            s.mem[s.count[4:0]]     = it.byte_in;
                            s.written[s.count[4:0]] = 1'b1;
                        end
                        if (s.count != COUNT_MAX)
                            s.count = s.count + 6'd1;
                        if (it.status == ST_RXDATA_NACK)
                            r.command = CMD_STOP;
                        else if ({1'b0, s.count} + 7'd1 < {1'b0, s.rx_len})
                            r.command = CMD_ACK;
                        else
                            r.command = CMD_NACK;
                    end
                    default:
                        r.command = CMD_STOP;
                endcase
            end
        endcase
        r.finished = (r.command == CMD_STOP);
        return r;
    endfunction

    function automatic stim_t mk_item(kind_t k, logic [3:0] st, logic [7:0] b, logic [4:0] sl);
        stim_t it;
        it.kind        = k;
        it.status      = st;
        it.byte_in     = b;
        it.slot        = sl;
        it.drain_first = 1'b0;
        return it;
    endfunction

    function automatic stim_t random_item();
        return mk_item(kind_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                       8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    endfunction

    // Queue an item; first store any buffer entry it would read while still unwritten.
    function automatic result_t plan_item(stim_t it);
        stim_t      fill;
        result_t    r;
        logic [5:0] idx;
        logic       reads;
        reads = 1'b0;
        idx   = 6'd0;
        if (it.kind == KIND_BUF_READ)
        begin
            idx   = {1'b0, it.slot};
            reads = 1'b1;
        end
        else if (it.kind == KIND_EVENT && (it.status == ST_SLAW_ACK ||
                 it.status == ST_TXDATA_ACK) && plan_state.count < plan_state.tx_len)
        begin
            idx   = plan_state.count;
            reads = 1'b1;
        end
        if (reads && !idx[5] && !plan_state.written[idx[4:0]])
        begin
            fill = mk_item(KIND_BUF_WRITE, 4'($urandom_range(0, 15)),
                           8'($urandom_range(0, 255)), idx[4:0]);
            r = sequencer_next(plan_state, fill);
            pending_items.push_back(fill);
            queued_items++;
        end
        r = sequencer_next(plan_state, it);
        pending_items.push_back(it);
        queued_items++;
        return r;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        want = '0;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_SLAVE_ADDR:
            begin
                bus_state.addr  = value[6:0];
                plan_state.addr = value[6:0];
                want            = {25'd0, value[6:0]};
            end
            REG_TX_LENGTH:
            begin
                bus_state.tx_len  = value[5:0];
                plan_state.tx_len = value[5:0];
                want              = {26'd0, value[5:0]};
            end
            REG_RX_LENGTH:
            begin
                bus_state.rx_len  = value[5:0];
                plan_state.rx_len = value[5:0];
                want              = {26'd0, value[5:0]};
            end
            default:
                want = '0;
        endcase
        if (idx != REG_SPARE)
        begin
            apb_access(1'b0, idx, 32'd0, rd);
            if (rd !== want)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("register %0d read back %h, expected %h", idx, rd, want);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || items_taken != items_sent ||
               pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One transaction that follows the bus protocol, with the odd stray item mixed in.
    task automatic run_transaction();
        result_t    step;
        result_t    spare;
        logic [3:0] st;
        logic       addr_next;
        int         guard;
        repeat ($urandom_range(0, 3))
            spare = plan_item(mk_item(($urandom_range(0, 3) == 0) ? KIND_BUF_READ : KIND_BUF_WRITE,
                                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                                      5'($urandom_range(0, 31))));
        step = plan_item(mk_item(KIND_START, 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31))));
        addr_next = 1'b0;
        guard     = 0;
        while (step.command != CMD_STOP && guard < 160)
        begin
            if ($urandom_range(0, 24) == 0)
                spare = plan_item(random_item());
            if ($urandom_range(0, 29) == 0)
                spare = plan_item(mk_item(KIND_EVENT, ST_ARBLOST, 8'($urandom_range(0, 255)),
                                          5'($urandom_range(0, 31))));
            case (step.command)
                CMD_START:
                begin
                    st        = ($urandom_range(0, 1) != 0) ? ST_START : ST_RSTART;
                    addr_next = 1'b1;
                end
                CMD_CONTINUE:
                begin
                    if (addr_next && plan_state.read_bit)
                        st = ($urandom_range(0, 11) == 0) ? ST_SLAR_NACK : ST_SLAR_ACK;
                    else if (addr_next)
                        st = ($urandom_range(0, 11) == 0) ? ST_SLAW_NACK : ST_SLAW_ACK;
                    else
                        st = ($urandom_range(0, 39) == 0) ? ST_TXDATA_NACK : ST_TXDATA_ACK;
                    addr_next = 1'b0;
                end
                CMD_ACK:
                    st = ST_RXDATA_ACK;
                CMD_NACK:
                    st = ST_RXDATA_NACK;
                default:
                    st = ST_OTHER;
            endcase
            // abort now and then with an unknown status
            if ($urandom_range(0, 49) == 0)
                st = ST_OTHER + 4'($urandom_range(0, 4));
            step = plan_item(mk_item(KIND_EVENT, st, 8'($urandom_range(0, 255)),
                                     5'($urandom_range(0, 31))));
            guard++;
        end
    endtask

    // Sender: hold the item until taken, then idle for a drawn number of cycles.
    always @(negedge clk)
    begin
        stim_t nxt;
        logic  go;
        logic  busy;
        go   = 1'b0;
        busy = in_valid && (items_taken != items_sent);
        if (rst_n && !busy)
        begin
            if (in_valid)
                send_left = draw_wait(send_calm);
            if (send_left > 0)
                send_left--;
            else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain_first || pending_results.size() == 0))
                go = 1'b1;
        end
        if (go)
        begin
            nxt = pending_items.pop_front();
            kind     <= nxt.kind;
            status   <= nxt.status;
            byte_in  <= nxt.byte_in;
            slot     <= nxt.slot;
            in_valid <= 1'b1;
            items_sent++;
        end
        else if (rst_n && !busy)
            in_valid <= 1'b0;
    end

    // Receiver: stall for a drawn number of cycles after each result.
    always @(negedge clk)
    begin
        if (results_seen != stall_mark)
        begin
            stall_mark = results_seen;
            stall_left = draw_wait(recv_calm);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        stim_t   taken;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.command    = cmd_t'(command);
                got.data_byte  = data_byte;
                got.data_valid = data_valid;
                got.finished   = finished;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result with none expected: cmd %0d byte %h dv %b fin %b",
                                 got.command, got.data_byte, got.data_valid, got.finished);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.command !== want.command || got.data_byte !== want.data_byte ||
                        got.data_valid !== want.data_valid || got.finished !== want.finished)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("result %0d: cmd %0d/%0d byte %h/%h dv %b/%b fin %b/%b (exp/got)",
                                     results_seen, want.command, got.command, want.data_byte,
                                     got.data_byte, want.data_valid, got.data_valid,
                                     want.finished, got.finished);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taken = mk_item(kind_t'(kind), status, byte_in, slot);
                pending_results.push_back(sequencer_next(bus_state, taken));
                items_taken++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        result_t spare;
        stim_t   last;
        int      budget;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_register(REG_SLAVE_ADDR, 32'd127);
        set_register(REG_TX_LENGTH, 32'd1);
        set_register(REG_RX_LENGTH, 32'd2);
        set_register(REG_SPARE, 32'hA5A5_5A5A);

        // Directed: buffer extremes, one full write-then-read, then every other status.
        spare = plan_item(mk_item(KIND_BUF_WRITE, 4'd0, 8'hFF, 5'd0));
        spare = plan_item(mk_item(KIND_BUF_WRITE, 4'd15, 8'h00, 5'd31));
        spare = plan_item(mk_item(KIND_BUF_READ, 4'd0, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_BUF_READ, 4'd15, 8'hFF, 5'd31));
        spare = plan_item(mk_item(KIND_START, 4'd15, 8'hFF, 5'd31));
        spare = plan_item(mk_item(KIND_EVENT, ST_START, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_SLAW_ACK, 8'hFF, 5'd31));
        spare = plan_item(mk_item(KIND_EVENT, ST_TXDATA_ACK, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_RSTART, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_SLAR_ACK, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_RXDATA_ACK, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_RXDATA_NACK, 8'hFF, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_ARBLOST, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_SLAW_NACK, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_TXDATA_NACK, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_SLAR_NACK, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, ST_OTHER, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_EVENT, 4'd15, 8'h00, 5'd0));
        spare = plan_item(mk_item(KIND_BUF_READ, 4'd0, 8'h00, 5'd1));
        // hold the sender until every result so far is back
        last = mk_item(KIND_START, 4'd0, 8'h00, 5'd0);
        last.drain_first = 1'b1;
        spare = plan_item(last);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    set_register(REG_SLAVE_ADDR, 32'd0);
                    set_register(REG_TX_LENGTH, 32'd0);
                    set_register(REG_RX_LENGTH, 32'd0);
                end
                1:
                begin
                    set_register(REG_SLAVE_ADDR, 32'd127);
                    set_register(REG_TX_LENGTH, 32'd32);
                    set_register(REG_RX_LENGTH, 32'd32);
                end
                2:
                begin
                    set_register(REG_SLAVE_ADDR, 32'h55);
                    set_register(REG_TX_LENGTH, 32'd63);
                    set_register(REG_RX_LENGTH, 32'd63);
                end
                3:
                begin
                    set_register(REG_SLAVE_ADDR, 32'h2A);
                    set_register(REG_TX_LENGTH, 32'd0);
                    set_register(REG_RX_LENGTH, 32'd1);
                end
                4:
                begin
                    set_register(REG_SLAVE_ADDR, 32'h01);
                    set_register(REG_TX_LENGTH, 32'd1);
                    set_register(REG_RX_LENGTH, 32'd0);
                end
                default:
                begin
                    set_register(REG_SLAVE_ADDR, $urandom_range(0, 127));
                    set_register(REG_TX_LENGTH, ($urandom_range(0, 5) == 0) ?
                                 $urandom_range(0, 32) : $urandom_range(0, 5));
                    set_register(REG_RX_LENGTH, ($urandom_range(0, 5) == 0) ?
                                 $urandom_range(0, 32) : $urandom_range(0, 5));
                end
            endcase
            budget = queued_items + PHASE_ITEMS;
            if (phase == 2)
            begin
                // drive the transfer count into saturation
                spare = plan_item(mk_item(KIND_EVENT, ST_RSTART, 8'h00, 5'd0));
                repeat (70)
                    spare = plan_item(mk_item(KIND_EVENT, ST_RXDATA_ACK,
                                              8'($urandom_range(0, 255)),
                                              5'($urandom_range(0, 31))));
            end
            while (queued_items < budget)
            begin
                run_transaction();
                repeat ($urandom_range(0, 2))
                    spare = plan_item(random_item());
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/i2cs_pkg.sv
hdl/i2cs_buf_ram.sv
hdl/i2cs_seq.sv
hdl/i2cs_out_q.sv
hdl/i2c_master_transaction_sequencer.sv
hdl/i2cs_checker.sv
verif/tb_i2c_master_transaction_sequencer.sv
